>>> sv/bwcc_pkg.sv
`default_nettype none
package bwcc_pkg;
  localparam int unsigned WallSlotsDef = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW = 15;
  localparam int unsigned DirW = 16;
  localparam int unsigned CntW = 5;
  localparam int unsigned HitIdxW = 4;
  // box corners and wall corners in Q.8 pixels
  localparam int unsigned PtW = 26;
  // edge vector components
  localparam int unsigned EdgeW = 27;
  // cross product terms
  localparam int unsigned ProdW = 55;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SETUP = 2'd1,
    ST_SCAN = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  localparam logic [0:0] RegWallCount = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
  } wall_t;

  typedef struct packed {
    logic signed [PtW-1:0] x0;
    logic signed [PtW-1:0] y0;
    logic signed [PtW-1:0] x1;
    logic signed [PtW-1:0] y1;
    logic signed [PtW-1:0] x2;
    logic signed [PtW-1:0] y2;
    logic signed [PtW-1:0] x3;
    logic signed [PtW-1:0] y3;
  } box_t;

  // round v*2^-7, ties up
  function automatic logic signed [PtW-1:0] round7(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = v + 35'sd64;
    return t[PtW+6:7];
  endfunction
endpackage
`default_nettype wire

>>> sv/bwcc_if.sv
`default_nettype none
interface bwcc_in_if;
  import bwcc_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [3:0] slot;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic [SizeW-1:0] size_w;
  logic [SizeW-1:0] size_h;
  logic signed [DirW-1:0] dir_cos;
  logic signed [DirW-1:0] dir_sin;
  modport source (output valid, op, slot, pos_x, pos_y, size_w, size_h, dir_cos, dir_sin,
                  input ready);
  modport sink (input valid, op, slot, pos_x, pos_y, size_w, size_h, dir_cos, dir_sin,
                output ready);
endinterface

interface bwcc_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [3:0] hit_wall;
  modport source (output valid, hit, hit_wall, input ready);
  modport sink (input valid, hit, hit_wall, output ready);
endinterface
`default_nettype wire

>>> sv/box_wall_collision_check.sv
// Channel | Dir | Payload
// in_req  | in  | op, slot, pos_x, pos_y, size_w, size_h, dir_cos, dir_sin
// out_req | out | hit, hit_wall
// apb     | in  | wall_count at 0x0
// One request at a time. A write is answered on the next cycle.
// A query first forms the box corners in the setup state, then scans n walls
// (n = wall_count capped at the table size, one wall fed a cycle, then the
// read register, four corner cells and one decision step to drain), then
// the result state, held until taken, and back to idle.
// Reset clears control state; the wall table has no reset.
// The result waits in the output register; the input is blocked meanwhile.
`default_nettype none
module box_wall_collision_check
  import bwcc_pkg::*;
#(
  parameter int unsigned WallSlots = WallSlotsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bwcc_in_if.sink     in_req,
  bwcc_out_if.source  out_req,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned IdxW = (WallSlots > 1) ? $clog2(WallSlots) : 1;
  localparam int unsigned NumW = $clog2(WallSlots + 1);

  state_e st_q, st_d;
  logic [CntW-1:0] wall_count_q;
  wall_t mem [WallSlots];
  box_t box_q, box_d;
  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] feed_q, feed_d;
  logic [2:0] drain_q, drain_d;
  logic res_hit_q, res_hit_d;
  logic [HitIdxW-1:0] res_idx_q, res_idx_d;
  logic feed_vld_q;
  wall_t rd_q;
  logic [IdxW-1:0] rd_idx_q;
  logic flush;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == {RegWallCount, 1'b0}) ? 32'(wall_count_q) : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_count_q <= '0;
    end else if (psel && penable && pwrite && paddr == {RegWallCount, 1'b0}) begin
      wall_count_q <= pwdata[CntW-1:0];
    end
  end

  // table write
  always_ff @(posedge clk_i) begin
    if (in_req.valid && in_req.ready && in_req.op == OP_WRITE
        && 32'(in_req.slot) < WallSlots) begin
      mem[IdxW'(in_req.slot)] <= '{x: in_req.pos_x, y: in_req.pos_y,
                                  w: in_req.size_w, h: in_req.size_h};
    end
  end

  // box corners
  logic signed [31:0] ah, bw, bh, aw;
  logic signed [PtW-1:0] cx, cy;
  always_comb begin
    ah = in_req.dir_cos * signed'({1'b0, in_req.size_h});
    bw = in_req.dir_sin * signed'({1'b0, in_req.size_w});
    bh = in_req.dir_sin * signed'({1'b0, in_req.size_h});
    aw = in_req.dir_cos * signed'({1'b0, in_req.size_w});
  end
  logic signed [31:0] ah_q, bw_q, bh_q, aw_q;
  logic signed [CoordW-1:0] cxq, cyq;
  always_ff @(posedge clk_i) begin
    if (in_req.valid && in_req.ready) begin
      ah_q <= ah; bw_q <= bw; bh_q <= bh; aw_q <= aw;
      cxq <= in_req.pos_x; cyq <= in_req.pos_y;
    end
  end
  always_comb begin
    cx = PtW'(cxq) <<< 8;
    cy = PtW'(cyq) <<< 8;
    box_d = box_q;
    if (st_q == ST_SETUP) begin
      box_d.x0 = cx + round7(35'(ah_q) + 35'(bw_q));
      box_d.y0 = cy + round7(35'(bh_q) - 35'(aw_q));
      box_d.x1 = cx + round7(35'(ah_q) - 35'(bw_q));
      box_d.y1 = cy + round7(35'(bh_q) + 35'(aw_q));
      box_d.x2 = cx + round7(-35'(ah_q) - 35'(bw_q));
      box_d.y2 = cy + round7(-35'(bh_q) + 35'(aw_q));
      box_d.x3 = cx + round7(-35'(ah_q) + 35'(bw_q));
      box_d.y3 = cy + round7(-35'(bh_q) - 35'(aw_q));
    end
  end

  // chain
  logic c_vld [5];
  wall_t c_wall [5];
  logic [IdxW-1:0] c_idx [5];
  logic c_hit [5];
  logic [IdxW-1:0] c_hidx [5];
  assign c_vld[0] = feed_vld_q;
  assign c_wall[0] = rd_q;
  assign c_idx[0] = rd_idx_q;
  assign c_hit[0] = 1'b0;
  assign c_hidx[0] = '0;
  for (genvar g = 0; g < 4; g++) begin : g_cell
    bwcc_cell #(.IdxW(IdxW), .Corner(g)) u_cell (
      .clk_i, .rst_ni, .flush_i(flush), .box_i(box_q),
      .vld_i(c_vld[g]), .wall_i(c_wall[g]), .idx_i(c_idx[g]),
      .hit_i(c_hit[g]), .hit_idx_i(c_hidx[g]),
      .vld_o(c_vld[g+1]), .wall_o(c_wall[g+1]), .idx_o(c_idx[g+1]),
      .hit_o(c_hit[g+1]), .hit_idx_o(c_hidx[g+1])
    );
  end
  assign flush = (st_q == ST_SETUP);

  always_comb begin
    st_d = st_q;
    num_d = num_q;
    feed_d = feed_q;
    drain_d = drain_q;
    res_hit_d = res_hit_q;
    res_idx_d = res_idx_q;
    in_req.ready = (st_q == ST_IDLE);
    case (st_q)
      ST_IDLE: begin
        if (in_req.valid) begin
          res_hit_d = 1'b0;
          res_idx_d = '0;
          if (in_req.op == OP_QUERY) begin
            st_d = ST_SETUP;
            num_d = (32'(wall_count_q) > WallSlots) ? NumW'(WallSlots)
                                                    : NumW'(wall_count_q);
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_SETUP: begin
        st_d = ST_SCAN;
        feed_d = '0;
        drain_d = '0;
      end
      ST_SCAN: begin
        if (feed_q < num_q) feed_d = feed_q + 1'b1;
        else drain_d = drain_q + 1'b1;
        // earliest hit wins: walls leave the chain in order
        if (c_vld[4] && c_hit[4] && !res_hit_q) begin
          res_hit_d = 1'b1;
          res_idx_d = HitIdxW'(c_hidx[4]);
        end
        if (drain_q == 3'd5) st_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_req.ready) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      feed_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      feed_vld_q <= (st_q == ST_SCAN) && (feed_q < num_q);
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
    num_q <= num_d;
    feed_q <= feed_d;
    drain_q <= drain_d;
    res_hit_q <= res_hit_d;
    res_idx_q <= res_idx_d;
    rd_q <= mem[feed_q[IdxW-1:0]];
    rd_idx_q <= feed_q[IdxW-1:0];
  end

  assign out_req.valid = (st_q == ST_DONE);
  assign out_req.hit = res_hit_q;
  assign out_req.hit_wall = res_idx_q;

  a_no_in_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !in_req.ready) else $error("busy but ready");
  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req.valid && in_req.ready && in_req.op == OP_WRITE) |=> out_req.valid)
    else $error("write result missing");
  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req.valid && in_req.ready && in_req.op == OP_WRITE) |=> !out_req.hit)
    else $error("write reports hit");
endmodule
`default_nettype wire

>>> sv/bwcc_cell.sv
`default_nettype none
// One corner cell: tests the wall corner it holds against the box, hands the
// wall on to the next cell each cycle.
module bwcc_cell
  import bwcc_pkg::*;
#(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Corner = 0
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               flush_i,
  input  wire box_t         box_i,
  input  wire               vld_i,
  input  wire wall_t        wall_i,
  input  wire [IdxW-1:0]    idx_i,
  input  wire               hit_i,
  input  wire [IdxW-1:0]    hit_idx_i,
  output logic              vld_o,
  output wall_t             wall_o,
  output logic [IdxW-1:0]   idx_o,
  output logic              hit_o,
  output logic [IdxW-1:0]   hit_idx_o
);
  logic signed [PtW-1:0] px, py;
  logic signed [PtW-1:0] bx [4];
  logic signed [PtW-1:0] by [4];
  logic signed [ProdW-1:0] cr [4];
  logic pos_seen, neg_seen, in_box;
  logic vld_q, hit_q;
  wall_t wall_q;
  logic [IdxW-1:0] idx_q, hit_idx_q;

  always_comb begin
    bx[0] = box_i.x0; by[0] = box_i.y0;
    bx[1] = box_i.x1; by[1] = box_i.y1;
    bx[2] = box_i.x2; by[2] = box_i.y2;
    bx[3] = box_i.x3; by[3] = box_i.y3;
    // wall corner is the integer position scaled by 256, Q.8
    if (Corner == 1 || Corner == 2) begin
      px = PtW'(18'(signed'(wall_i.x)) + 18'(signed'({1'b0, wall_i.w}))) <<< 8;
    end else begin
      px = PtW'(signed'(wall_i.x)) <<< 8;
    end
    if (Corner == 2 || Corner == 3) begin
      py = PtW'(18'(signed'(wall_i.y)) + 18'(signed'({1'b0, wall_i.h}))) <<< 8;
    end else begin
      py = PtW'(signed'(wall_i.y)) <<< 8;
    end
    pos_seen = 1'b0;
    neg_seen = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cr[k] = ProdW'(EdgeW'(px) - EdgeW'(bx[k])) * ProdW'(EdgeW'(by[(k+1)%4]) - EdgeW'(by[k]))
            - ProdW'(EdgeW'(py) - EdgeW'(by[k])) * ProdW'(EdgeW'(bx[(k+1)%4]) - EdgeW'(bx[k]));
      if (cr[k] > 0) pos_seen = 1'b1;
      if (cr[k] < 0) neg_seen = 1'b1;
    end
    in_box = !(pos_seen && neg_seen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else if (flush_i) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
      hit_q <= hit_i || (vld_i && in_box);
    end
  end

  always_ff @(posedge clk_i) begin
    wall_q <= wall_i;
    idx_q <= idx_i;
    if (!hit_i) hit_idx_q <= idx_i;
    else hit_idx_q <= hit_idx_i;
  end

  assign vld_o = vld_q;
  assign wall_o = wall_q;
  assign idx_o = idx_q;
  assign hit_o = hit_q;
  assign hit_idx_o = hit_idx_q;
endmodule
`default_nettype wire

>>> dv/bwcc_check.sv
`timescale 1ns / 1ps
`default_nettype none
module bwcc_check
  import bwcc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  bwcc_in_if         in_req,
  bwcc_out_if        out_req,
  input  wire [4:0]  wall_count_i,
  output int         fail_count_o,
  output int         pending_o
);
  typedef struct {
    logic       hit;
    logic [3:0] hit_wall;
  } verdict_t;

  logic signed [15:0] tab_x[16];
  logic signed [15:0] tab_y[16];
  logic [14:0]        tab_w[16];
  logic [14:0]        tab_h[16];
  verdict_t           verdicts_q[$];
  int                 fails = 0;

  assign pending_o = verdicts_q.size();
  assign fail_count_o = fails;

  function automatic longint rnd7(longint v);
    longint t;
    t = v + 64;
    return t >>> 7;
  endfunction

  function automatic bit corner_in_box(longint bx[4], longint by[4], longint px, longint py);
    int sgn;
    int nx;
    longint c;
    sgn = 0;
    for (int k = 0; k < 4; k++) begin
      nx = (k + 1) % 4;
      c = (px - bx[k]) * (by[nx] - by[k]) - (py - by[k]) * (bx[nx] - bx[k]);
      if (c != 0) begin
        if (sgn == 0) sgn = (c > 0) ? 1 : -1;
        else if ((c > 0 ? 1 : -1) != sgn) return 0;
      end
    end
    return 1;
  endfunction

  function automatic verdict_t scan_walls(longint cx, longint cy, longint sw, longint sh,
                                          longint ca, longint sb);
    verdict_t r;
    longint bx[4], by[4], wx[4], wy[4];
    longint ah, bw, bh, aw, x0, y0, x1, y1;
    int n;
    r.hit = 0;
    r.hit_wall = '0;
    ah = ca * sh; bw = sb * sw; bh = sb * sh; aw = ca * sw;
    bx[0] = cx * 256 + rnd7(ah + bw);  by[0] = cy * 256 + rnd7(bh - aw);
    bx[1] = cx * 256 + rnd7(ah - bw);  by[1] = cy * 256 + rnd7(bh + aw);
    bx[2] = cx * 256 + rnd7(-ah - bw); by[2] = cy * 256 + rnd7(-bh + aw);
    bx[3] = cx * 256 + rnd7(-ah + bw); by[3] = cy * 256 + rnd7(-bh - aw);
    n = (wall_count_i > 16) ? 16 : wall_count_i;
    for (int i = 0; i < n; i++) begin
      x0 = longint'(tab_x[i]) * 256;
      y0 = longint'(tab_y[i]) * 256;
      x1 = (longint'(tab_x[i]) + longint'(tab_w[i])) * 256;
      y1 = (longint'(tab_y[i]) + longint'(tab_h[i])) * 256;
      wx = '{x0, x1, x1, x0};
      wy = '{y0, y0, y1, y1};
      for (int k = 0; k < 4; k++)
        if (corner_in_box(bx, by, wx[k], wy[k])) begin
          r.hit = 1;
          r.hit_wall = i[3:0];
          return r;
        end
    end
    return r;
  endfunction

  task automatic report(string what, logic [3:0] got, logic [3:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && in_req.valid && in_req.ready) begin
      v.hit = 0;
      v.hit_wall = '0;
      if (in_req.op == OP_WRITE) begin
        tab_x[in_req.slot] = in_req.pos_x;
        tab_y[in_req.slot] = in_req.pos_y;
        tab_w[in_req.slot] = in_req.size_w;
        tab_h[in_req.slot] = in_req.size_h;
      end else begin
        v = scan_walls(in_req.pos_x, in_req.pos_y, in_req.size_w, in_req.size_h,
                       in_req.dir_cos, in_req.dir_sin);
      end
      verdicts_q.insert(verdicts_q.size(), v);
    end
    if (rst_ni && out_req.valid && out_req.ready) begin
      if (verdicts_q.size() == 0) begin
        report("unexpected result", out_req.hit_wall, 4'd0);
      end else begin
        v = verdicts_q.pop_front();
        if (out_req.hit !== v.hit) report("hit", {3'b0, out_req.hit}, {3'b0, v.hit});
        if (out_req.hit_wall !== v.hit_wall) report("hit_wall", out_req.hit_wall, v.hit_wall);
      end
    end
  end
endmodule
`default_nettype wire

>>> dv/box_wall_collision_check_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// Stimulus for the wall collision block. Walls are loaded through write
// requests, wall_count is set over APB between phases while idle, and then
// queries with random boxes run through eight phases of four handshake pressure settings.
// The checker beside the block predicts every result.
module box_wall_collision_check_tb;
  import bwcc_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [4:0]  wall_count_q = '0;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  longint      cycle_count = 0;
  // slots written so far; a query only uses walls below the first unwritten one
  bit          slot_loaded[16];

  bwcc_in_if  in_req();
  bwcc_out_if out_req();

  box_wall_collision_check uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_req(in_req), .out_req(out_req),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bwcc_check checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_req(in_req), .out_req(out_req),
    .wall_count_i(wall_count_q), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_req.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop; a slow correct run takes well under this
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("[box_wall_collision_check] ERROR");
      $finish;
    end
  end

  // valid stays up when the next request follows at once
  task automatic send_request(logic op, logic [3:0] slot, logic [15:0] px, logic [15:0] py,
                              logic [14:0] sw, logic [14:0] sh, logic [15:0] dc,
                              logic [15:0] ds);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 0;
      @(posedge clk_i);
    end
    in_req.valid   <= 1;
    in_req.op      <= op;
    in_req.slot    <= slot;
    in_req.pos_x   <= px;
    in_req.pos_y   <= py;
    in_req.size_w  <= sw;
    in_req.size_h  <= sh;
    in_req.dir_cos <= dc;
    in_req.dir_sin <= ds;
    do @(posedge clk_i); while (!in_req.ready);
    if (op == OP_WRITE) slot_loaded[slot] = 1;
  endtask

  task automatic drain;
    in_req.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // APB write of wall_count; only called while idle
  task automatic set_wall_count(logic [4:0] n);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'd0; pwdata <= {27'd0, n};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    wall_count_q = n;
  endtask

  // count limited to the written prefix so no unwritten entry is read
  function automatic logic [4:0] legal_count(logic [4:0] want);
    int k;
    k = 0;
    while (k < 16 && slot_loaded[k]) k++;
    return (k == 16 && want >= 16) ? want : ((want > k) ? 5'(k) : want);
  endfunction

  task automatic random_wall(logic [3:0] s);
    logic [15:0] x, y;
    x = $urandom_range(1) ? 16'($urandom) : 16'($signed($urandom_range(2000)) - 1000);
    y = $urandom_range(1) ? 16'($urandom) : 16'($signed($urandom_range(2000)) - 1000);
    send_request(OP_WRITE, s, x, y, $urandom_range(3) == 0 ? 15'($urandom) :
                 15'($urandom_range(400)), $urandom_range(3) == 0 ? 15'($urandom) :
                 15'($urandom_range(400)), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_query;
    int ang;
    logic [15:0] dc, ds;
    ang = $urandom_range(7);
    // mostly unit headings, sometimes anything
    case (ang)
      0: begin dc = 16'sd16384;  ds = 16'sd0; end
      1: begin dc = 16'sd11585;  ds = 16'sd11585; end
      2: begin dc = -16'sd16384; ds = 16'sd0; end
      3: begin dc = 16'sd0;      ds = -16'sd16384; end
      4: begin dc = -16'sd11585; ds = 16'sd11585; end
      default: begin dc = 16'($urandom); ds = 16'($urandom); end
    endcase
    send_request(OP_QUERY, 4'($urandom), $urandom_range(3) == 0 ? 16'($urandom) :
                 16'($signed($urandom_range(2400)) - 1200),
                 $urandom_range(3) == 0 ? 16'($urandom) :
                 16'($signed($urandom_range(2400)) - 1200),
                 $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(800)),
                 $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(800)), dc, ds);
  endtask

  initial begin
    in_req.valid = 0; in_req.op = OP_WRITE; in_req.slot = '0;
    in_req.pos_x = '0; in_req.pos_y = '0; in_req.size_w = '0; in_req.size_h = '0;
    in_req.dir_cos = '0; in_req.dir_sin = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: count 0, then extreme walls and boxes
    send_request(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_WRITE, 0, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 0, 0);
    send_request(OP_WRITE, 1, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    send_request(OP_WRITE, 2, 0, 0, 16, 16, 0, 0);
    send_request(OP_WRITE, 3, 16'shffff, 16'sh0001, 15'h4000, 15'h0001, 0, 0);
    drain();
    set_wall_count(4);
    // degenerate box at the origin, box touching a corner on its edge
    send_request(OP_QUERY, 0, 0, 0, 0, 0, 16384, 0);
    send_request(OP_QUERY, 0, 16, 16, 32, 32, 16384, 0);
    send_request(OP_QUERY, 15, 16'sh7fff, 16'sh8000, 15'h7fff, 15'h7fff,
                 16'sh8000, 16'sh8000);
    send_request(OP_QUERY, 0, 16'sh8000, 16'sh7fff, 15'h7fff, 15'h7fff,
                 16'sh7fff, 16'sh7fff);
    send_request(OP_QUERY, 0, 8, 8, 4, 4, 16'sd11585, -16'sd11585);
    send_request(OP_QUERY, 0, 0, 0, 0, 100, 16384, 0);
    send_request(OP_QUERY, 0, 0, 0, 15'h7fff, 15'h7fff, 16'shffff, 16'sh0001);
    drain();

    for (int s = 4; s < 16; s++) random_wall(4'(s));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (ph)
        0: set_wall_count(16);
        1: set_wall_count(31);
        2: set_wall_count(0);
        3: set_wall_count(1);
        default: set_wall_count(legal_count(5'($urandom)));
      endcase
      for (int i = 0; i < 210; i++) begin
        // rewrites keep the table changing under a fixed count
        if ($urandom_range(4) == 0) random_wall(4'($urandom));
        else random_query();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[box_wall_collision_check] OK");
    end else begin
      $display("[box_wall_collision_check] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
sv/bwcc_pkg.sv
sv/bwcc_if.sv
sv/bwcc_cell.sv
sv/box_wall_collision_check.sv
dv/bwcc_check.sv
dv/box_wall_collision_check_tb.sv
